>>> rtl/core/itra_pkg.sv
package itra_pkg;

    localparam int MAX_DIGITS  = 64;
    localparam int DIG_W       = 6;
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int MAG_W       = 64;
    localparam int BITS_PER_CY = 8;
    localparam int DIV_STEPS   = MAG_W / BITS_PER_CY;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [5:0] DEC_LIMIT  = 6'd10;

    // output character source
    localparam logic [1:0] SEL_DIGIT = 2'd0;
    localparam logic [1:0] SEL_SIGN  = 2'd1;
    localparam logic [1:0] SEL_ZERO  = 2'd2;

    typedef struct packed {
        logic signed [63:0] value;
        logic [5:0]         radix;
    } itra_in_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       final_res;
    } itra_out_t;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       div_first;
        logic       div_last;
        logic       dig_rd;
        logic       cnt_dec;
        logic       out_load;
        logic [1:0] out_sel;
        logic       out_final;
    } itra_cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic neg;
        logic cnt_one;
        logic cnt_hi;
        logic out_free;
    } itra_status_t;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        logic [7:0] c;
        if (d < DEC_LIMIT)
        begin
            c = CHAR_ZERO + {2'b00, d};
        end
        else
        begin
            c = CHAR_A + {2'b00, d - DEC_LIMIT};
        end
        return c;
    endfunction

endpackage

>>> rtl/core/itra_ctrl.sv
module itra_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   num_valid,
    output logic                   num_stall,
    input  itra_pkg::itra_status_t st,
    output itra_pkg::itra_cmd_t    cmd
);
    import itra_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_NEXT  = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_LOAD  = 3'd6;
    localparam logic [2:0] S_ZERO  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign num_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.out_sel = SEL_DIGIT;
        case (state_reg)
            S_IDLE:
            begin
                if (num_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                step_next  = '0;
                state_next = st.mag_zero ? S_ZERO : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (step_reg == '0);
                cmd.div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));
                step_next     = step_reg + 1'b1;
                if (cmd.div_last)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                // quotient is now in place: more digits or start readout
                if (!st.mag_zero)
                begin
                    state_next = S_DIV;
                end
                else if (st.neg)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_SIGN:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_SIGN;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                cmd.dig_rd = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (st.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = SEL_DIGIT;
                    cmd.out_final = st.cnt_one;
                    cmd.cnt_dec   = 1'b1;
                    state_next    = st.cnt_one ? S_IDLE : S_RD;
                end
            end
            S_ZERO:
            begin
                if (st.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = SEL_ZERO;
                    cmd.out_final = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> rtl/core/itra_dpath.sv
module itra_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  itra_pkg::itra_in_t     num_data,
    input  itra_pkg::itra_cmd_t    cmd,
    output itra_pkg::itra_status_t st,
    output logic                   txt_valid,
    input  logic                   txt_stall,
    output itra_pkg::itra_out_t    txt_data
);
    import itra_pkg::*;

    logic [MAG_W-1:0]  q_reg, q_next;
    logic [DIG_W-1:0]  rem_reg, rem_next;
    logic [5:0]        radix_reg, radix_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    itra_out_t         out_reg, out_next;
    logic [DIG_W-1:0]  rd_data_reg;
    logic [DIG_W-1:0]  dig_mem [MAX_DIGITS];

    logic [5:0]             radix_in;
    logic [MAG_W-1:0]       neg_mag;
    logic [MAG_W-1:0]       mag_in;
    logic [DIG_W-1:0]       r;
    logic [DIG_W:0]         t;
    logic [BITS_PER_CY-1:0] qb;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   out_free;

    assign out_free = !out_valid_reg || !txt_stall;
    assign rd_addr  = ADDR_W'(cnt_reg - 1'b1);

    always_comb
    begin
        // clamp base into 2..36
        if (num_data.radix < RADIX_MIN)
        begin
            radix_in = RADIX_MIN;
        end
        else if (num_data.radix > RADIX_MAX)
        begin
            radix_in = RADIX_MAX;
        end
        else
        begin
            radix_in = num_data.radix;
        end

        neg_mag = MAG_W'(-num_data.value);
        if (!num_data.value[MAG_W-1])
        begin
            mag_in = {1'b0, num_data.value[MAG_W-2:0]};
        end
        else if (neg_mag[MAG_W-1])
        begin
            // most negative value saturates
            mag_in = {1'b0, {(MAG_W-1){1'b1}}};
        end
        else
        begin
            mag_in = neg_mag;
        end
    end

    // restoring division, several quotient bits per cycle
    always_comb
    begin
        r  = cmd.div_first ? '0 : rem_reg;
        qb = '0;
        t  = '0;
        for (int k = 0; k < BITS_PER_CY; k++)
        begin
            t = {r, q_reg[MAG_W-1-k]};
            if (t >= {1'b0, radix_reg})
            begin
                qb[BITS_PER_CY-1-k] = 1'b1;
                r = DIG_W'(t - {1'b0, radix_reg});
            end
            else
            begin
                r = DIG_W'(t);
            end
        end
    end

    always_comb
    begin
        q_next     = q_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            q_next     = mag_in;
            radix_next = radix_in;
            neg_next   = num_data.value[MAG_W-1];
            cnt_next   = '0;
        end
        else if (cmd.div_step)
        begin
            q_next   = {q_reg[MAG_W-BITS_PER_CY-1:0], qb};
            rem_next = r;
            if (cmd.div_last)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.out_load)
        begin
            out_next.final_res = cmd.out_final;
            case (cmd.out_sel)
                SEL_SIGN: out_next.text_char = CHAR_MINUS;
                SEL_ZERO: out_next.text_char = CHAR_ZERO;
                default:  out_next.text_char = digit_char(rd_data_reg);
            endcase
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!txt_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= '0;
            rem_reg       <= '0;
            radix_reg     <= '0;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            q_reg         <= q_next;
            rem_reg       <= rem_next;
            radix_reg     <= radix_next;
            neg_reg       <= neg_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // digit store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.div_last)
        begin
            dig_mem[cnt_reg[ADDR_W-1:0]] <= r;
        end
        if (cmd.dig_rd)
        begin
            rd_data_reg <= dig_mem[rd_addr];
        end
    end

    assign st.mag_zero = (q_reg == '0);
    assign st.neg      = neg_reg;
    assign st.cnt_one  = (cnt_reg == CNT_W'(1));
    assign st.cnt_hi   = cnt_reg[CNT_W-1];
    assign st.out_free = out_free;

    assign txt_valid = out_valid_reg;
    assign txt_data  = out_reg;

endmodule

>>> rtl/core/integer_to_radix_ascii_top.sv
// each number passes S_CHECK, then the division of all its D digits, before the first character; a negative
// number sends its sign first, zero a single '0'; a new number is taken once the last one's final char is loaded
// the divider resolves 8 quotient bits a cycle, then tests the quotient in S_NEXT for more digits
// readout takes each character through the registered read of the digit store (S_RD, then S_LOAD)
// reset: rst_n clears control, counters and output valid; the digit store is not reset
module integer_to_radix_ascii_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    output logic                num_stall,
    input  itra_pkg::itra_in_t  num_data,
    output logic                txt_valid,
    input  logic                txt_stall,
    output itra_pkg::itra_out_t txt_data
);
    import itra_pkg::*;

    itra_cmd_t    cmd;
    itra_status_t st;

    itra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .st        (st),
        .cmd       (cmd)
    );

    itra_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_data  (num_data),
        .cmd       (cmd),
        .st        (st),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .txt_data  (txt_data)
    );

`ifndef SYNTHESIS
    // never overwrite a character still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("output register overwritten");

    // digit store never written past its depth
    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_last |-> !st.cnt_hi)
        else $error("digit store overflow");

    // a new item starts with an empty digit count
    a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (!st.cnt_hi && !st.cnt_one))
        else $error("digit count not cleared on load");

    // digits are read out only once the division has finished
    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> st.mag_zero)
        else $error("digit readout out of order");
`endif

endmodule

>>> bench/itra_text_checker.sv
`timescale 1ns / 100ps
module itra_text_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                num_valid,
    input  logic                num_stall,
    input  itra_pkg::itra_in_t  num_data,
    input  logic                txt_valid,
    input  logic                txt_stall,
    input  itra_pkg::itra_out_t txt_data,
    output int                  mismatches,
    output int                  chars_due
);
    import itra_pkg::*;

    itra_out_t text_due[$];
    itra_out_t want;
    int        chars_seen;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
        $display("%0t: mismatch on %s at char %0d: got %0h, want %0h",
                 $realtime, what, chars_seen, got, wanted);
        mismatches++;
    endtask

    // clamps the base, splits the magnitude into digits and queues the text, sign first, then most significant first
    function automatic void predict_text(input itra_in_t item);
        logic [63:0] mag;
        logic [5:0]  base;
        logic [5:0]  digits[$];
        logic        neg;
        itra_out_t   ch;
        base = item.radix;
        if (base < RADIX_MIN)
        begin
            base = RADIX_MIN;
        end
        if (base > RADIX_MAX)
        begin
            base = RADIX_MAX;
        end
        neg = item.value[63];
        mag = neg ? (~item.value + 64'd1) : item.value;
        // the most negative value saturates to the largest magnitude
        if (mag > 64'h7FFF_FFFF_FFFF_FFFF)
        begin
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (mag == 64'd0)
        begin
            ch.text_char = CHAR_ZERO;
            ch.final_res = 1'b1;
            text_due.push_back(ch);
            return;
        end
        while (mag != 64'd0)
        begin
            digits.push_back(6'(mag % {58'd0, base}));
            mag = mag / {58'd0, base};
        end
        if (neg)
        begin
            ch.text_char = CHAR_MINUS;
            ch.final_res = 1'b0;
            text_due.push_back(ch);
        end
        for (int i = digits.size() - 1; i >= 0; i--)
        begin
            if (digits[i] < 6'd10)
            begin
                ch.text_char = CHAR_ZERO + {2'b00, digits[i]};
            end
            else
            begin
                ch.text_char = CHAR_A + {2'b00, digits[i] - 6'd10};
            end
            ch.final_res = (i == 0);
            text_due.push_back(ch);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (txt_valid && !txt_stall)
            begin
                if (text_due.size() == 0)
                begin
                    flag_mismatch("char with nothing due", {56'd0, txt_data.text_char}, 64'd0);
                end
                else
                begin
                    want = text_due.pop_front();
                    if (txt_data.text_char !== want.text_char)
                    begin
                        flag_mismatch("text_char", {56'd0, txt_data.text_char},
                                      {56'd0, want.text_char});
                    end
                    if (txt_data.final_res !== want.final_res)
                    begin
                        flag_mismatch("final_res", {63'd0, txt_data.final_res},
                                      {63'd0, want.final_res});
                    end
                end
                chars_seen++;
            end
            if (num_valid && !num_stall)
            begin
                predict_text(num_data);
            end
            chars_due = text_due.size();
        end
    end

endmodule

>>> bench/tb_integer_to_radix_ascii_top.sv
`timescale 1ns / 100ps
module tb_integer_to_radix_ascii_top;
    import itra_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_LIMIT   = 6000;
    localparam int DRAIN_CYCLES = 64;

    logic      clk;
    logic      rst_n;
    logic      num_valid;
    logic      num_stall;
    itra_in_t  num_data;
    logic      txt_valid;
    logic      txt_stall;
    itra_out_t txt_data;
    int        mismatches;
    int        chars_due;
    int        idle_cycles;
    bit        tx_busy;
    bit        rx_busy;

    integer_to_radix_ascii_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_stall (num_stall),
        .num_data  (num_data),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .txt_data  (txt_data)
    );

    itra_text_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_valid  (num_valid),
        .num_stall  (num_stall),
        .num_data   (num_data),
        .txt_valid  (txt_valid),
        .txt_stall  (txt_stall),
        .txt_data   (txt_data),
        .mismatches (mismatches),
        .chars_due  (chars_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sends one number, after a random gap unless in a quiet stretch
    task automatic send_number(input logic [63:0] v, input logic [5:0] r);
        int       gap;
        itra_in_t item;
        if ($urandom_range(0, 23) == 0)
        begin
            tx_busy = !tx_busy;
        end
        gap = tx_busy ? $urandom_range(0, 12) : 0;
        item.value = v;
        item.radix = r;
        @(negedge clk);
        if (gap != 0)
        begin
            num_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        num_data  <= item;
        num_valid <= 1'b1;
        @(posedge clk);
        while (num_stall)
        begin
            @(posedge clk);
        end
    endtask

    // character side: random stall before each character
    initial
    begin
        int gap;
        txt_stall = 1'b1;
        rx_busy   = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 31) == 0)
            begin
                rx_busy = !rx_busy;
            end
            gap = rx_busy ? $urandom_range(0, 12) : 0;
            if (gap != 0)
            begin
                txt_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            txt_stall <= 1'b0;
            @(posedge clk);
            while (!txt_valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (num_valid && !num_stall) || (txt_valid && !txt_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] v;
        logic [63:0] raw;
        logic [5:0]  r;
        int          pick;
        rst_n     = 1'b0;
        num_valid = 1'b0;
        num_data  = '0;
        tx_busy   = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_number(64'd0, 6'd10);
        send_number(64'd1, 6'd2);
        send_number(-64'd1, 6'd2);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd2);
        send_number(64'h8000_0000_0000_0001, 6'd2);
        // most negative value, saturated magnitude
        send_number(64'h8000_0000_0000_0000, 6'd2);
        send_number(64'h8000_0000_0000_0000, 6'd36);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd36);
        send_number(64'd35, 6'd36);
        send_number(64'd36, 6'd36);
        send_number(64'd255, 6'd16);
        send_number(-64'd12345, 6'd10);
        // base below range clamps to 2, above range to 36
        send_number(64'd5, 6'd0);
        send_number(-64'd6, 6'd1);
        send_number(64'd100, 6'd37);
        send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd63);
        send_number(64'd0, 6'd0);
        send_number(64'h5555_5555_5555_5555, 6'd3);
        send_number(64'hAAAA_AAAA_AAAA_AAAA, 6'd7);
        send_number(64'd9, 6'd10);
        send_number(64'd10, 6'd11);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 3);
            raw  = {$urandom, $urandom};
            case (pick)
                0:
                begin
                    v = raw;
                end
                1:
                begin
                    v = 64'($urandom_range(0, 40));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        v = -v;
                    end
                end
                default:
                begin
                    v = raw >> $urandom_range(0, 63);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        v = -v;
                    end
                end
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                r = 6'($urandom_range(0, 63));
            end
            else
            begin
                r = 6'($urandom_range(2, 36));
            end
            send_number(v, r);
        end

        @(negedge clk);
        num_valid <= 1'b0;
        while (chars_due != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && chars_due == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
